### rtl/pfe_pkg.sv
// ============================================================================
// pfe_pkg
// Shared types, codes and constants of the postfix expression evaluator.
// ============================================================================
package pfe_pkg;

    // Stack and number format
    localparam int STACK_DEPTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int VAL_W         = 48;
    localparam int SP_W          = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W        = $clog2(STACK_DEPTH);

    // Iteration counts of the shared arithmetic unit
    localparam int MUL_STEPS = VAL_W;
    localparam int DIV_STEPS = VAL_W + FRACTION_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // Saturation limits
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_INVALID   = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_R,
        S_RD_L,
        S_ALU_GO,
        S_ALU_WAIT,
        S_FIN_RD,
        S_FIN_OUT
    } t_state;

    // States of the arithmetic unit
    typedef enum logic [1:0] {
        A_IDLE,
        A_RUN,
        A_FIN
    } t_alu_state;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] value;
    } t_alu_rsp;

endpackage

### rtl/pfe_stack.sv
// ============================================================================
// pfe_stack
// Operand stack storage: one write port, one registered read port.
// ============================================================================
module pfe_stack (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [pfe_pkg::ADDR_W-1:0]  i_wr_addr,
    input  logic [pfe_pkg::VAL_W-1:0]   i_wr_data,
    input  logic [pfe_pkg::ADDR_W-1:0]  i_rd_addr,
    output logic [pfe_pkg::VAL_W-1:0]   o_rd_data
);

    logic [pfe_pkg::VAL_W-1:0] r_mem [pfe_pkg::STACK_DEPTH];
    logic [pfe_pkg::VAL_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/pfe_alu.sv
// ============================================================================
// pfe_alu
// Shared arithmetic unit: saturating add/subtract in one pass, multiply by
// shift-and-add one bit per cycle, divide by restoring division one bit per
// cycle. A single 50-bit adder serves all operations.
// ============================================================================
module pfe_alu (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pfe_pkg::t_alu_req         i_req,
    input  logic [pfe_pkg::VAL_W-1:0] i_a,
    input  logic [pfe_pkg::VAL_W-1:0] i_b,
    output pfe_pkg::t_alu_rsp         o_rsp
);

    localparam int W  = pfe_pkg::VAL_W;
    localparam int FB = pfe_pkg::FRACTION_BITS;
    localparam logic [W:0] HALF = {2'b01, {(W-1){1'b0}}};

    pfe_pkg::t_alu_state r_state, n_state;
    pfe_pkg::t_op        r_op;
    logic [pfe_pkg::CNT_W-1:0] r_cnt;
    logic                r_neg;
    logic [W-1:0]        r_x;     // multiplicand / left addend
    logic [W-1:0]        r_y;     // divisor / right addend
    logic [W:0]          r_hi;    // product high half / remainder
    logic [W-1:0]        r_lo;    // multiplier / dividend shift register
    logic [W:0]          r_q;
    logic                r_big;
    logic                r_done;
    logic [W-1:0]        r_value;

    logic [W+1:0]        add_x, add_y, add_s;
    logic                add_sub;
    logic                last_step;
    logic [W:0]          n_hi;
    logic [W-1:0]        n_lo;
    logic [W:0]          n_q;
    logic                n_big;
    logic                div_ge;
    logic [W:0]          mul_hi;
    logic [W:0]          div_sh;
    logic [2*W-1:0]      prod;
    logic [W-1:0]        fin_value;

    // Absolute value of a signed operand
    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        mag_of = v[W-1] ? ('0 - v) : v;
    endfunction

    // Signed result from sign, magnitude and overrange flag, saturated
    function automatic logic [W-1:0] sat_mag(input logic neg, input logic [W:0] mag,
                                             input logic big);
        if (neg) begin
            sat_mag = (big || mag >= HALF) ? pfe_pkg::VAL_MIN : ('0 - mag[W-1:0]);
        end else begin
            sat_mag = (big || mag >= HALF) ? pfe_pkg::VAL_MAX : mag[W-1:0];
        end
    endfunction

    // Shared adder operand selection
    always_comb begin
        add_x   = {1'b0, r_hi};
        add_y   = {2'b00, r_x};
        add_sub = 1'b0;
        if (r_state == pfe_pkg::A_RUN && r_op == pfe_pkg::OP_DIV) begin
            add_x   = {1'b0, r_hi[W-1:0], r_lo[W-1]};
            add_y   = {2'b00, r_y};
            add_sub = 1'b1;
        end else if (r_state == pfe_pkg::A_FIN) begin
            add_x   = {{2{r_x[W-1]}}, r_x};
            add_y   = {{2{r_y[W-1]}}, r_y};
            add_sub = (r_op == pfe_pkg::OP_SUB);
        end
        add_s = add_x + (add_sub ? ~add_y : add_y) + {{(W+1){1'b0}}, add_sub};
    end

    // One iteration step of multiply or divide
    always_comb begin
        mul_hi = r_lo[0] ? add_s[W:0] : r_hi;
        div_sh = {r_hi[W-1:0], r_lo[W-1]};
        div_ge = ~add_s[W+1];
        n_hi   = r_hi;
        n_lo   = r_lo;
        n_q    = r_q;
        n_big  = r_big;
        if (r_op == pfe_pkg::OP_MUL) begin
            n_hi = {1'b0, mul_hi[W:1]};
            n_lo = {mul_hi[0], r_lo[W-1:1]};
        end else begin
            n_hi = div_ge ? add_s[W:0] : div_sh;
            n_lo = {r_lo[W-2:0], 1'b0};
            n_q  = r_big ? r_q : {r_q[W-1:0], div_ge};
            n_big = r_big | (n_q > HALF);
        end
        last_step = (r_op == pfe_pkg::OP_MUL)
                  ? (r_cnt == pfe_pkg::CNT_W'(pfe_pkg::MUL_STEPS - 1))
                  : (r_cnt == pfe_pkg::CNT_W'(pfe_pkg::DIV_STEPS - 1));
    end

    // Final result formatting
    always_comb begin
        prod = {r_hi[W-1:0], r_lo};
        case (r_op)
            pfe_pkg::OP_ADD, pfe_pkg::OP_SUB: begin
                if (add_s[W] != add_s[W-1]) begin
                    fin_value = add_s[W] ? pfe_pkg::VAL_MIN : pfe_pkg::VAL_MAX;
                end else begin
                    fin_value = add_s[W-1:0];
                end
            end
            pfe_pkg::OP_MUL: begin
                fin_value = sat_mag(r_neg, {1'b0, prod[FB+W-1:FB]}, |prod[2*W-1:FB+W]);
            end
            default: begin
                fin_value = sat_mag(r_neg, r_q, r_big);
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfe_pkg::A_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == pfe_pkg::OP_ADD || i_req.op == pfe_pkg::OP_SUB) begin
                        n_state = pfe_pkg::A_FIN;
                    end else begin
                        n_state = pfe_pkg::A_RUN;
                    end
                end
            end
            pfe_pkg::A_RUN: begin
                if (last_step) begin
                    n_state = pfe_pkg::A_FIN;
                end
            end
            pfe_pkg::A_FIN: begin
                n_state = pfe_pkg::A_IDLE;
            end
            default: begin
                n_state = pfe_pkg::A_IDLE;
            end
        endcase
    end

    // State and done flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfe_pkg::A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == pfe_pkg::A_FIN);
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            pfe_pkg::A_IDLE: begin
                if (i_req.start) begin
                    r_op  <= i_req.op;
                    r_neg <= i_a[W-1] ^ i_b[W-1];
                    r_cnt <= '0;
                    r_hi  <= '0;
                    r_q   <= '0;
                    r_big <= 1'b0;
                    case (i_req.op)
                        pfe_pkg::OP_MUL: begin
                            r_x  <= mag_of(i_a);
                            r_lo <= mag_of(i_b);
                        end
                        pfe_pkg::OP_DIV: begin
                            r_y  <= mag_of(i_b);
                            r_lo <= mag_of(i_a);
                        end
                        default: begin
                            r_x <= i_a;
                            r_y <= i_b;
                        end
                    endcase
                end
            end
            pfe_pkg::A_RUN: begin
                r_hi  <= n_hi;
                r_lo  <= n_lo;
                r_q   <= n_q;
                r_big <= n_big;
                r_cnt <= r_cnt + pfe_pkg::CNT_W'(1);
            end
            pfe_pkg::A_FIN: begin
                r_value <= fin_value;
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

endmodule

### rtl/postfix_expression_evaluator_core.sv
// ============================================================================
// postfix_expression_evaluator_core
// Postfix (RPN) evaluator on signed Q32.16 values with an operand stack.
// ============================================================================
// Characters enter one request at a time on the slave stream; tlast marks the
// last character of an expression, which produces one result on the master
// stream (value in the low 48 bits, status above it) and then empties the
// stack. The block takes one character at a time and is not ready while it
// works on it: a digit is pushed, a stray character flagged, and an operator
// reads both operands and runs the shared arithmetic unit, which adds in one
// pass, divides in 48 + FRACTION_BITS iterations and multiplies and divides one
// bit per cycle. A last character adds a read of the stack top. A result waits
// in an output register, so new characters are taken while it is held.
module postfix_expression_evaluator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tlast,   // end_of_expression
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // [47:0] value, [50:48] status, zero above
);

    localparam int W = pfe_pkg::VAL_W;
    localparam int AW = pfe_pkg::ADDR_W;
    localparam int SW = pfe_pkg::SP_W;

    pfe_pkg::t_state   r_state, n_state;
    logic [SW-1:0]     r_sp, n_sp;
    pfe_pkg::t_status  r_err, n_err;
    logic [7:0]        r_char;
    logic              r_last;
    pfe_pkg::t_op      r_op;
    logic [W-1:0]      r_right;
    logic              r_out_valid;
    logic [W-1:0]      r_out_value;
    pfe_pkg::t_status  r_out_status;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [W-1:0]      wr_data;
    logic [AW-1:0]     rd_addr;
    logic [W-1:0]      rd_data;
    logic [SW-1:0]     sp_m1, sp_m2;
    logic              is_digit, is_op;
    pfe_pkg::t_op      dec_op;
    logic [3:0]        digit;
    logic              err_note;
    pfe_pkg::t_status  err_code;
    logic              out_free, out_load;
    pfe_pkg::t_state   end_state;
    pfe_pkg::t_alu_req alu_req;
    pfe_pkg::t_alu_rsp alu_rsp;

    // Operand stack and arithmetic unit
    pfe_stack u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    pfe_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (rd_data),
        .i_b     (r_right),
        .o_rsp   (alu_rsp)
    );

    // Character decode
    always_comb begin
        is_digit = (r_char >= pfe_pkg::CH_ZERO) && (r_char <= pfe_pkg::CH_NINE);
        digit    = 4'(r_char - pfe_pkg::CH_ZERO);
        is_op    = 1'b1;
        case (r_char)
            pfe_pkg::CH_PLUS:  dec_op = pfe_pkg::OP_ADD;
            pfe_pkg::CH_MINUS: dec_op = pfe_pkg::OP_SUB;
            pfe_pkg::CH_STAR:  dec_op = pfe_pkg::OP_MUL;
            pfe_pkg::CH_SLASH: dec_op = pfe_pkg::OP_DIV;
            default: begin
                dec_op = pfe_pkg::OP_ADD;
                is_op  = 1'b0;
            end
        endcase
    end

    assign sp_m1     = r_sp - SW'(1);
    assign sp_m2     = r_sp - SW'(2);
    assign out_free  = !r_out_valid || m_axis_tready;
    assign end_state = r_last ? pfe_pkg::S_FIN_RD : pfe_pkg::S_IDLE;

    // Sequencer: next state and control
    always_comb begin
        n_state  = r_state;
        n_sp     = r_sp;
        wr_en    = 1'b0;
        wr_addr  = r_sp[AW-1:0];
        wr_data  = W'(digit) << pfe_pkg::FRACTION_BITS;
        rd_addr  = sp_m1[AW-1:0];
        err_note = 1'b0;
        err_code = pfe_pkg::ST_OK;
        out_load = 1'b0;
        alu_req.start = 1'b0;
        alu_req.op    = r_op;
        case (r_state)
            pfe_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = pfe_pkg::S_DECODE;
                end
            end
            pfe_pkg::S_DECODE: begin
                n_state = end_state;
                if (is_digit) begin
                    if (r_sp == SW'(pfe_pkg::STACK_DEPTH)) begin
                        err_note = 1'b1;
                        err_code = pfe_pkg::ST_OVERFLOW;
                    end else begin
                        wr_en = 1'b1;
                        n_sp  = r_sp + SW'(1);
                    end
                end else if (is_op) begin
                    if (r_sp < SW'(2)) begin
                        err_note = 1'b1;
                        err_code = pfe_pkg::ST_UNDERFLOW;
                    end else begin
                        n_state = pfe_pkg::S_RD_R;
                    end
                end else begin
                    err_note = 1'b1;
                    err_code = pfe_pkg::ST_INVALID;
                end
            end
            pfe_pkg::S_RD_R: begin
                n_state = pfe_pkg::S_RD_L;
            end
            pfe_pkg::S_RD_L: begin
                rd_addr = sp_m2[AW-1:0];
                n_state = pfe_pkg::S_ALU_GO;
            end
            pfe_pkg::S_ALU_GO: begin
                if (r_op == pfe_pkg::OP_DIV && r_right == '0) begin
                    err_note = 1'b1;
                    err_code = pfe_pkg::ST_DIVZERO;
                    n_state  = end_state;
                end else begin
                    alu_req.start = 1'b1;
                    n_state       = pfe_pkg::S_ALU_WAIT;
                end
            end
            pfe_pkg::S_ALU_WAIT: begin
                if (alu_rsp.done) begin
                    wr_en   = 1'b1;
                    wr_addr = sp_m2[AW-1:0];
                    wr_data = alu_rsp.value;
                    n_sp    = sp_m1;
                    n_state = end_state;
                end
            end
            pfe_pkg::S_FIN_RD: begin
                n_state = pfe_pkg::S_FIN_OUT;
            end
            pfe_pkg::S_FIN_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_sp     = '0;
                    n_state  = pfe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfe_pkg::S_IDLE;
            end
        endcase
    end

    // First error since the last report is kept
    always_comb begin
        n_err = r_err;
        if (out_load) begin
            n_err = pfe_pkg::ST_OK;
        end else if (err_note && r_err == pfe_pkg::ST_OK) begin
            n_err = err_code;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfe_pkg::S_IDLE;
            r_sp        <= '0;
            r_err       <= pfe_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_err   <= n_err;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, operand capture and result register
    always_ff @(posedge i_clk) begin
        if (r_state == pfe_pkg::S_IDLE && s_axis_tvalid) begin
            r_char <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
        if (r_state == pfe_pkg::S_DECODE) begin
            r_op <= dec_op;
        end
        if (r_state == pfe_pkg::S_RD_L) begin
            r_right <= rd_data;
        end
        if (out_load) begin
            r_out_value <= (r_sp != '0) ? rd_data : '0;
            if (r_err != pfe_pkg::ST_OK) begin
                r_out_status <= r_err;
            end else if (r_sp == '0) begin
                r_out_status <= pfe_pkg::ST_EMPTY;
            end else begin
                r_out_status <= pfe_pkg::ST_OK;
            end
        end
    end

    assign s_axis_tready = (r_state == pfe_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_status, r_out_value};

    // Checks
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SW'(pfe_pkg::STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_alu_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == pfe_pkg::S_ALU_WAIT))
        else $error("arithmetic result outside wait state");

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_sp == '0 && r_err == pfe_pkg::ST_OK && r_out_valid))
        else $error("report did not clear stack and error");

    a_op_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |-> (r_sp >= SW'(2)))
        else $error("operator started with fewer than two operands");

endmodule
